// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros expect clk and rst_n in scope.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/b2bcd_pkg.sv =====
`default_nettype none

package b2bcd_pkg;

    localparam int INPUT_WIDTH    = 64;
    localparam int MAX_DIGITS     = 20;
    localparam int DATA_WIDTH     = 64;
    localparam int BCD_WIDTH      = MAX_DIGITS * 4;
    localparam int BIT_CNT_W      = (INPUT_WIDTH > 1) ? $clog2(INPUT_WIDTH) : 1;
    localparam int DIGIT_W        = 4;
    localparam int IDX_W          = 5;
    localparam int OUT_DATA_WIDTH = 16;
    localparam int OUT_PAD        = OUT_DATA_WIDTH - DIGIT_W - 2 * IDX_W;

    typedef struct packed {
        logic capture;      // take input word into the holding register
        logic load;         // start a conversion from the holding register
        logic shift;        // one shift-and-add-3 step
        logic count_check;  // update digit count from the BCD register
        logic advance;      // step to the next output digit
    } cmd_t;

    typedef struct packed {
        logic shift_last;   // current shift handles the last input bit
        logic last_digit;   // digit on the output is the most significant one
    } status_t;

endpackage

`default_nettype wire

// ===== design/b2bcd_controller.sv =====
`default_nettype none

module b2bcd_controller
    import b2bcd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CONV   = 2'd1;
    localparam logic [1:0] ST_SETTLE = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       full_reg;
    logic       full_next;

    assign s_tready = !full_reg;
    assign m_tvalid = (state_reg == ST_EMIT);

    always_comb
    begin
        cmd             = '0;
        cmd.capture     = s_tvalid && !full_reg;
        state_next      = state_reg;
        full_next       = full_reg;
        if (cmd.capture)
        begin
            full_next = 1'b1;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (full_reg)
                begin
                    cmd.load   = 1'b1;
                    full_next  = 1'b0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.shift       = 1'b1;
                cmd.count_check = 1'b1;
                if (status.shift_last)
                begin
                    state_next = ST_SETTLE;
                end
            end
            ST_SETTLE:
            begin
                // one more check sees the value after the final shift
                cmd.count_check = 1'b1;
                state_next      = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (m_tready)
                begin
                    cmd.advance = 1'b1;
                    if (status.last_digit)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            full_reg  <= full_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/b2bcd_datapath.sv =====
`default_nettype none

module b2bcd_datapath
    import b2bcd_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic [DATA_WIDTH-1:0]     in_data,
    input  wire cmd_t                      cmd,
    output status_t                        status,
    output logic [OUT_DATA_WIDTH-1:0]      out_data,
    output logic                           out_last
);

    logic [INPUT_WIDTH-1:0] hold_reg;
    logic [INPUT_WIDTH-1:0] bin_reg;
    logic [INPUT_WIDTH-1:0] bin_next;
    logic [BCD_WIDTH-1:0]   bcd_reg;
    logic [BCD_WIDTH-1:0]   bcd_next;
    logic [BCD_WIDTH-1:0]   bcd_adj;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg;
    logic [BIT_CNT_W-1:0]   bit_cnt_next;
    logic [IDX_W-1:0]       cnt_reg;
    logic [IDX_W-1:0]       cnt_next;
    logic [IDX_W-1:0]       pos_reg;
    logic [IDX_W-1:0]       pos_next;
    logic                   grow;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int j = 0; j < MAX_DIGITS; j++)
        begin
            if (bcd_reg[4*j +: 4] >= 4'd5)
            begin
                bcd_adj[4*j +: 4] = bcd_reg[4*j +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*j +: 4] = bcd_reg[4*j +: 4];
            end
        end
    end

    // the value at most doubles per shift, so the count grows by one at most;
    // the count saturates at MAX_DIGITS since no digit sits at that index
    always_comb
    begin
        grow = 1'b0;
        for (int j = 0; j < MAX_DIGITS; j++)
        begin
            if (cnt_reg == IDX_W'(j) && bcd_reg[4*j +: 4] != 4'd0)
            begin
                grow = 1'b1;
            end
        end
    end

    always_comb
    begin
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        priority if (cmd.load)
        begin
            bin_next     = hold_reg;
            bcd_next     = '0;
            bit_cnt_next = '0;
            cnt_next     = IDX_W'(1);
            pos_next     = '0;
        end
        else if (cmd.shift)
        begin
            bin_next     = {bin_reg[INPUT_WIDTH-2:0], 1'b0};
            bcd_next     = {bcd_adj[BCD_WIDTH-2:0], bin_reg[INPUT_WIDTH-1]};
            bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
        end
        else if (cmd.advance)
        begin
            bcd_next = {4'd0, bcd_reg[BCD_WIDTH-1:4]};
            pos_next = pos_reg + IDX_W'(1);
        end
        if (cmd.count_check && grow)
        begin
            cnt_next = cnt_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            hold_reg <= in_data[INPUT_WIDTH-1:0];
        end
        bin_reg     <= bin_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        cnt_reg     <= cnt_next;
        pos_reg     <= pos_next;
    end

    assign status.shift_last = (bit_cnt_reg == BIT_CNT_W'(INPUT_WIDTH - 1));
    assign status.last_digit = (pos_reg == cnt_reg - IDX_W'(1));
    assign out_last          = status.last_digit;
    assign out_data          = {{OUT_PAD{1'b0}}, cnt_reg, pos_reg, bcd_reg[3:0]};

endmodule

`default_nettype wire

// ===== design/binary_to_bcd_converter.sv =====
`default_nettype none

// Binary to BCD converter. Each 64-bit word taken on the s_ side is turned into
// its decimal digits, sent on the m_ side one word per digit, units first,
// with no leading zeros (zero gives one digit 0); tlast marks the most
// significant digit. A conversion has a load step, one shift-and-add-3 step
// per input bit (64 steps), and a step to settle the digit count; then the
// digits, up to 20, go out one per handshake, held while m_tready is low.
// The double dabble register shifts one bit per cycle.
// A single holding register takes the next input word while digits of the
// previous one are still going out.
`include "assert_macros.svh"

module binary_to_bcd_converter
    import b2bcd_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [DATA_WIDTH-1:0]     s_tdata,   // [63:0] binary_value
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // [3:0] decimal_digit, [8:4] digit_position, [13:9] digit_count, [15:14] zero
    output logic [OUT_DATA_WIDTH-1:0]      m_tdata,
    output logic                           m_tlast    // last_digit
);

    cmd_t    cmd;
    status_t status;

    b2bcd_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    b2bcd_datapath u_dp (
        .clk      (clk),
        .in_data  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .out_data (m_tdata),
        .out_last (m_tlast)
    );

    `ASSERT_ALWAYS(a_digit_range, !m_tvalid || m_tdata[3:0] <= 4'd9, "digit above 9")
    `ASSERT_ALWAYS(a_pos_below_count, !m_tvalid || m_tdata[8:4] < m_tdata[13:9],
        "digit position not below count")
    `ASSERT_NEXT(a_run_ends, m_tvalid && m_tready && m_tlast, !m_tvalid,
        "digit sent after last digit")
    `ASSERT_NEXT(a_pos_steps, m_tvalid && m_tready && !m_tlast,
        m_tvalid && m_tdata[8:4] == $past(m_tdata[8:4]) + 5'd1,
        "digit position did not step by one")

endmodule

`default_nettype wire

// ===== dv/binary_to_bcd_converter_test.sv =====
module binary_to_bcd_converter_test;
    import b2bcd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT_WORD = 60;
    localparam int RANDOM_ITEMS = 150;
    localparam int MAX_SHOWN    = 50;

    typedef struct {
        logic [3:0] digit;
        logic [4:0] position;
        logic [4:0] count;
        logic       last;
    } bcd_digit_t;

    typedef struct {
        logic [DATA_WIDTH-1:0] value;
        string                 shown;   // decimal text, empty when left to the predictor
    } stim_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [DATA_WIDTH-1:0]     s_tdata;      // [63:0] binary_value
    logic                      m_tvalid;
    logic                      m_tready;
    // [3:0] decimal_digit, [8:4] digit_position, [13:9] digit_count, [15:14] zero
    logic [OUT_DATA_WIDTH-1:0] m_tdata;
    logic                      m_tlast;      // last_digit

    bcd_digit_t expected_digits[$];
    stim_row_t  directed_rows[$];
    int         mismatches = 0;
    int         words_seen = 0;
    int         values_sent = 0;
    bit         receiver_holding = 0;

    binary_to_bcd_converter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("word %0d: %s", words_seen, what);
    endtask

    // digits of the value, units first, no leading zeros
    task automatic predict_digits(logic [DATA_WIDTH-1:0] value);
        logic [DATA_WIDTH-1:0] rest;
        logic [3:0]            held[MAX_DIGITS];
        int                    n;
        bcd_digit_t            d;
        rest = value & ({DATA_WIDTH{1'b1}} >> (DATA_WIDTH - INPUT_WIDTH));
        n = 0;
        do
        begin
            held[n] = 4'(rest % 10);
            rest = rest / 10;
            n++;
        end while (rest != 0 && n < MAX_DIGITS);
        for (int k = 0; k < n; k++)
        begin
            d.digit    = held[k];
            d.position = 5'(k);
            d.count    = 5'(n);
            d.last     = (k == n - 1);
            expected_digits.push_back(d);
        end
    endtask

    // expectation typed as decimal text, most significant character first
    task automatic expect_shown(string shown);
        bcd_digit_t d;
        int         len;
        len = shown.len();
        for (int k = len - 1; k >= 0; k--)
        begin
            d.digit    = 4'(shown[k] - "0");
            d.position = 5'(len - 1 - k);
            d.count    = 5'(len);
            d.last     = (k == 0);
            expected_digits.push_back(d);
        end
    endtask

    function automatic int draw_wait(int seen, int period);
        if ((seen / period) % 3 == 1)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [DATA_WIDTH-1:0] random_value();
        logic [DATA_WIDTH-1:0] v;
        logic [DATA_WIDTH-1:0] p;
        int                    pick;
        int                    k;
        pick = $urandom_range(0, 9);
        v = {$urandom, $urandom};
        p = 1;
        unique case (pick)
            4, 5, 6: v = v >> $urandom_range(0, DATA_WIDTH - 1);
            7:
            begin
                // one below, at or above a power of ten
                k = $urandom_range(1, 19);
                repeat (k) p = p * 10;
                v = p + $urandom_range(0, 2) - 1;
            end
            8: v = $urandom_range(0, 99);
            9: v = ~64'd0 - $urandom_range(0, 999);
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_value(logic [DATA_WIDTH-1:0] value, string shown);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (shown.len() != 0)
            expect_shown(shown);
        else
            predict_digits(value);
        values_sent++;
        gap = receiver_holding ? 0 : draw_wait(values_sent, 20);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic check_word(logic [OUT_DATA_WIDTH-1:0] data, logic tlast);
        bcd_digit_t want;
        if (expected_digits.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word %h last %b", data, tlast));
            return;
        end
        want = expected_digits.pop_front();
        if (data[DIGIT_W-1:0] !== want.digit)
            report_mismatch($sformatf("digit %0d, expected %0d",
                                      data[DIGIT_W-1:0], want.digit));
        if (data[DIGIT_W +: IDX_W] !== want.position)
            report_mismatch($sformatf("position %0d, expected %0d",
                                      data[DIGIT_W +: IDX_W], want.position));
        if (data[DIGIT_W + IDX_W +: IDX_W] !== want.count)
            report_mismatch($sformatf("count %0d, expected %0d",
                                      data[DIGIT_W + IDX_W +: IDX_W], want.count));
        if (data[OUT_DATA_WIDTH-1:DIGIT_W + 2 * IDX_W] !== '0)
            report_mismatch($sformatf("pad bits %b not zero",
                                      data[OUT_DATA_WIDTH-1:DIGIT_W + 2 * IDX_W]));
        if (tlast !== want.last)
            report_mismatch($sformatf("tlast %b, expected %b", tlast, want.last));
    endtask

    // receiver: random stalls, one long hold-off so the input side backs up
    initial
    begin
        int gap;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (words_seen == HOLD_AT_WORD && !receiver_holding)
            begin
                receiver_holding = 1'b1;
                gap = HOLD_CYCLES;
            end
            else
            begin
                receiver_holding = 1'b0;
                gap = draw_wait(words_seen, 40);
            end
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            check_word(m_tdata, m_tlast);
            words_seen++;
        end
    end

    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;

        directed_rows.push_back('{64'd0, "0"});
        directed_rows.push_back('{64'd1, "1"});
        directed_rows.push_back('{64'd9, "9"});
        directed_rows.push_back('{64'd10, "10"});
        directed_rows.push_back('{64'd11, "11"});
        directed_rows.push_back('{64'd99, "99"});
        directed_rows.push_back('{64'd100, "100"});
        directed_rows.push_back('{64'd255, "255"});
        directed_rows.push_back('{64'd65535, "65535"});
        directed_rows.push_back('{64'hFFFF_FFFF, "4294967295"});
        directed_rows.push_back('{64'h7FFF_FFFF_FFFF_FFFF, "9223372036854775807"});
        directed_rows.push_back('{64'h8000_0000_0000_0000, "9223372036854775808"});
        directed_rows.push_back('{64'd1000000000000000000, "1000000000000000000"});
        directed_rows.push_back('{64'd9999999999999999999, "9999999999999999999"});
        directed_rows.push_back('{64'd10000000000000000000, "10000000000000000000"});
        directed_rows.push_back('{64'd12345678901234567890, "12345678901234567890"});
        directed_rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, "18446744073709551615"});
        directed_rows.push_back('{64'hAAAA_AAAA_AAAA_AAAA, ""});
        directed_rows.push_back('{64'h5555_5555_5555_5555, ""});
        directed_rows.push_back('{64'h0000_0000_8000_0001, ""});
        directed_rows.push_back('{64'h0123_4567_89AB_CDEF, ""});
        directed_rows.push_back('{64'd0, "0"});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_value(directed_rows[i].value, directed_rows[i].shown);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_value(random_value(), "");
        s_tvalid <= 1'b0;

        while (expected_digits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_digits.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
